// ----- rtl/cabpu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cabpu_pkg
// Types and constants shared by the clipped alpha-blend pixel unit.
// ----------------------------------------------------------------------------
package cabpu_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_X        = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y        = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_W        = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_H        = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 4'd7;

	localparam logic [14:0] CLIP_W_RST        = 15'd256;
	localparam logic [14:0] CLIP_H_RST        = 15'd256;
	localparam logic [8:0]  CANVAS_WIDTH_RST  = 9'd256;
	localparam logic [8:0]  CANVAS_HEIGHT_RST = 9'd256;

	localparam logic [31:0] OUTSIDE_PIXEL = 32'hFF00_0000;
	localparam logic [7:0]  FULL_ALPHA    = 8'hFF;

	localparam logic FUNC_SET = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	typedef struct packed {
		logic        func;
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] color;
	} in_t;

	typedef struct packed {
		logic [31:0] read_pixel;
		logic        wrote;
	} out_t;

	typedef struct packed {
		logic [15:0] offset_x;
		logic [15:0] offset_y;
		logic [15:0] clip_x;
		logic [15:0] clip_y;
		logic [14:0] clip_w;
		logic [14:0] clip_h;
		logic [8:0]  canvas_width;
		logic [8:0]  canvas_height;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_MUL,
		ST_WR
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/cabpu_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cabpu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cabpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cabpu_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cabpu_cfg
// Configuration register file: offset, clip rectangle and canvas size.
// ----------------------------------------------------------------------------
module cabpu_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [cabpu_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [15:0]                    wr_data,
	output      cabpu_pkg::cfg_t                cfg
);

	cabpu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x      <= '0;
			cfg_q.offset_y      <= '0;
			cfg_q.clip_x        <= '0;
			cfg_q.clip_y        <= '0;
			cfg_q.clip_w        <= cabpu_pkg::CLIP_W_RST;
			cfg_q.clip_h        <= cabpu_pkg::CLIP_H_RST;
			cfg_q.canvas_width  <= cabpu_pkg::CANVAS_WIDTH_RST;
			cfg_q.canvas_height <= cabpu_pkg::CANVAS_HEIGHT_RST;
		end else if (wr_en) begin
			case (wr_index)
				cabpu_pkg::REG_OFFSET_X:      cfg_q.offset_x      <= wr_data;
				cabpu_pkg::REG_OFFSET_Y:      cfg_q.offset_y      <= wr_data;
				cabpu_pkg::REG_CLIP_X:        cfg_q.clip_x        <= wr_data;
				cabpu_pkg::REG_CLIP_Y:        cfg_q.clip_y        <= wr_data;
				cabpu_pkg::REG_CLIP_W:        cfg_q.clip_w        <= wr_data[14:0];
				cabpu_pkg::REG_CLIP_H:        cfg_q.clip_h        <= wr_data[14:0];
				cabpu_pkg::REG_CANVAS_WIDTH:  cfg_q.canvas_width  <= wr_data[8:0];
				cabpu_pkg::REG_CANVAS_HEIGHT: cfg_q.canvas_height <= wr_data[8:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/cabpu_mix.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cabpu_mix
// Per-channel alpha blend: registered products, then exact divide by 255.
// ----------------------------------------------------------------------------
module cabpu_mix (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] old_pixel,
	input  wire logic [31:0] color,
	output      logic [31:0] blended
);

	logic [15:0] sum_s1 [3];
	logic [7:0]  chan   [3];
	logic [7:0]  alpha;
	logic [7:0]  inv_alpha;

	assign alpha     = color[31:24];
	assign inv_alpha = cabpu_pkg::FULL_ALPHA - alpha;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sum_s1[c] <= 16'(old_pixel[8*c +: 8] * inv_alpha) + 16'(color[8*c +: 8] * alpha);
			end
		end
	end

	// v / 255 == (v + 1 + (v >> 8)) >> 8 for v below 65535
	always_comb begin
		logic [16:0] t;
		t = '0;
		for (int c = 0; c < 3; c++) begin
			t       = {1'b0, sum_s1[c]} + 17'd1 + {9'b0, sum_s1[c][15:8]};
			chan[c] = t[15:8];
		end
	end

	assign blended = {cabpu_pkg::FULL_ALPHA, chan[2], chan[1], chan[0]};

endmodule
`default_nettype wire

// ----- rtl/clipped_alpha_blend_pixel_unit_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_alpha_blend_pixel_unit_core
// Framebuffer pixel unit with clip rectangle, canvas offset and alpha blend.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the pixel memory to zero, one word a cycle, over
// all MAX_WIDTH*MAX_HEIGHT words; in_ready stays low meanwhile, configuration
// writes are taken at any time. Each request then passes through the states
// ADDR (address multiply and memory read), MUL (blend multiply) and WR
// (divide and write-back) before its result is valid. The pixel memory has
// one read and one write port. Only one request is in flight, so a new
// request is accepted only after the previous one has left WR. The result
// sits in an output register, so a new request is accepted while the previous
// result waits; its write-back then stalls until that result is taken.
module clipped_alpha_blend_pixel_unit_core #(
	parameter int MAX_WIDTH  = cabpu_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cabpu_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire cabpu_pkg::in_t                  in_data,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      cabpu_pkg::out_t                 out_data,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [cabpu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                     cfg_data
);

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int Aw    = $clog2(Depth);

	cabpu_pkg::cfg_t   cfg;
	cabpu_pkg::state_t state_q, state_d;
	cabpu_pkg::in_t    item_q;
	cabpu_pkg::out_t   out_q;

	logic [Aw-1:0] clr_q;
	logic [Aw-1:0] addr_q;
	logic          hit_q;
	logic [31:0]   pix_q;
	logic          out_valid_q;

	logic          clr_last;
	logic          go_wr;
	logic          ld_item;
	logic          ld_addr;
	logic          rd_en;
	logic          mix_en;
	logic          ram_we;
	logic [Aw-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;
	logic [31:0]   blended;

	logic               is_get;
	logic [7:0]         alpha;
	logic [8:0]         eff_w;
	logic [8:0]         eff_h;
	logic signed [16:0] px_c;
	logic signed [16:0] py_c;
	logic signed [17:0] px_w;
	logic signed [17:0] py_w;
	logic signed [17:0] clip_lo_x;
	logic signed [17:0] clip_lo_y;
	logic signed [17:0] clip_hi_x;
	logic signed [17:0] clip_hi_y;
	logic               in_clip;
	logic               on_canvas;
	logic               hit_c;
	logic [18:0]        index_c;
	logic [31:0]        new_pixel;

	cabpu_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;

	// Address stage
	assign is_get = (item_q.func == cabpu_pkg::FUNC_GET);
	assign alpha  = item_q.color[31:24];
	assign eff_w  = ({23'b0, cfg.canvas_width} > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg.canvas_width;
	assign eff_h  = ({23'b0, cfg.canvas_height} > MAX_HEIGHT) ? 9'(MAX_HEIGHT)
		: cfg.canvas_height;

	always_comb begin
		if (is_get) begin
			px_c = $signed({item_q.x[15], item_q.x});
			py_c = $signed({item_q.y[15], item_q.y});
		end else begin
			px_c = $signed({item_q.x[15], item_q.x}) + $signed({cfg.offset_x[15], cfg.offset_x});
			py_c = $signed({item_q.y[15], item_q.y}) + $signed({cfg.offset_y[15], cfg.offset_y});
		end
	end

	assign px_w      = $signed({px_c[16], px_c});
	assign py_w      = $signed({py_c[16], py_c});
	assign clip_lo_x = $signed({{2{cfg.clip_x[15]}}, cfg.clip_x});
	assign clip_lo_y = $signed({{2{cfg.clip_y[15]}}, cfg.clip_y});
	assign clip_hi_x = clip_lo_x + $signed({3'b0, cfg.clip_w});
	assign clip_hi_y = clip_lo_y + $signed({3'b0, cfg.clip_h});
	assign in_clip   = (px_w >= clip_lo_x) && (px_w < clip_hi_x)
		&& (py_w >= clip_lo_y) && (py_w < clip_hi_y);
	assign on_canvas = !px_c[16] && (px_c[15:0] < {7'b0, eff_w})
		&& !py_c[16] && (py_c[15:0] < {7'b0, eff_h});
	assign hit_c     = on_canvas && (is_get || ((alpha != 8'd0) && in_clip));
	assign index_c   = {1'b0, 18'(py_c[8:0] * eff_w)} + {10'b0, px_c[8:0]};

	// Control
	assign clr_last = (clr_q == Aw'(Depth - 1));
	assign go_wr    = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cabpu_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = cabpu_pkg::ST_IDLE;
				end
			end
			cabpu_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = cabpu_pkg::ST_ADDR;
				end
			end
			cabpu_pkg::ST_ADDR: state_d = cabpu_pkg::ST_MUL;
			cabpu_pkg::ST_MUL:  state_d = cabpu_pkg::ST_WR;
			cabpu_pkg::ST_WR: begin
				if (go_wr) begin
					state_d = cabpu_pkg::ST_IDLE;
				end
			end
			default: state_d = cabpu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ld_addr  = 1'b0;
		rd_en    = 1'b0;
		mix_en   = 1'b0;
		ram_we   = 1'b0;
		case (state_q)
			cabpu_pkg::ST_CLEAR: ram_we = 1'b1;
			cabpu_pkg::ST_IDLE:  in_ready = 1'b1;
			cabpu_pkg::ST_ADDR: begin
				ld_addr = 1'b1;
				rd_en   = hit_c;
			end
			cabpu_pkg::ST_MUL: mix_en = 1'b1;
			cabpu_pkg::ST_WR:  ram_we = go_wr && !is_get && hit_q;
			default: ;
		endcase
	end

	assign ld_item = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cabpu_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cabpu_pkg::ST_CLEAR) begin
				clr_q <= clr_q + Aw'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_item) begin
			item_q <= in_data;
		end
		if (ld_addr) begin
			hit_q  <= hit_c;
			addr_q <= Aw'(index_c);
		end
		if (mix_en) begin
			pix_q <= ram_rdata;
		end
	end

	// Pixel memory
	assign ram_waddr = (state_q == cabpu_pkg::ST_CLEAR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == cabpu_pkg::ST_CLEAR) ? '0 : new_pixel;

	cabpu_ram #(
		.WIDTH (32),
		.DEPTH (Depth)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (Aw'(index_c)),
		.rdata (ram_rdata)
	);

	cabpu_mix u_mix (
		.clk       (clk),
		.en        (mix_en),
		.old_pixel (ram_rdata),
		.color     (item_q.color),
		.blended   (blended)
	);

	assign new_pixel = (alpha == cabpu_pkg::FULL_ALPHA) ? item_q.color : blended;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == cabpu_pkg::ST_WR && go_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cabpu_pkg::ST_WR && go_wr) begin
			if (is_get) begin
				out_q.read_pixel <= hit_q ? pix_q : cabpu_pkg::OUTSIDE_PIXEL;
				out_q.wrote      <= 1'b0;
			end else begin
				out_q.read_pixel <= '0;
				out_q.wrote      <= hit_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q != cabpu_pkg::ST_CLEAR |-> state_q == cabpu_pkg::ST_WR && hit_q
			&& !is_get)
		else $error("pixel memory written outside a committing set");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == cabpu_pkg::ST_ADDR)
		else $error("accepted request did not enter the address stage");

	a_wrote_zero_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.wrote |-> out_data.read_pixel == 32'd0)
		else $error("set result carries a pixel value");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cabpu_pkg::ST_CLEAR |-> !in_ready && !out_valid)
		else $error("request activity during the clearing sweep");

endmodule
`default_nettype wire
